/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* sv/eilt_pkg.sv */
`default_nettype none
package eilt_pkg;

	localparam int EILT_TABLE_ENTRIES = 1024;
	localparam int EILT_VERTEX_BITS   = 16;
	localparam int EILT_POSITION_BITS = 20;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_WALK   = 1'b1;

	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_UNUSED = 2'd3;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic rd;
		logic cmp;
		logic wr;
		logic advance;
		logic emit;
	} eilt_cmd_t;

	typedef struct packed {
		logic needs_probe;
		logic clr_last;
		logic hit;
		logic empty;
		logic last_probe;
		logic is_insert;
		logic out_free;
	} eilt_stat_t;

endpackage
`default_nettype wire

/* sv/eilt_ram.sv */
`default_nettype none
module eilt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* sv/eilt_ctrl.sv */
`default_nettype none
module eilt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire eilt_pkg::eilt_stat_t  stat,
	output eilt_pkg::eilt_cmd_t        cmd
);
	import eilt_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_CMP   = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.needs_probe) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				priority if (stat.hit) begin
					state_d = stat.is_insert ? S_IDLE : S_EMIT;
				end else if (stat.empty) begin
					cmd.wr  = stat.is_insert;
					state_d = stat.is_insert ? S_IDLE : S_EMIT;
				end else if (stat.last_probe) begin
					state_d = S_EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* sv/eilt_datapath.sv */
`default_nettype none
module eilt_datapath #(
	parameter int TABLE_ENTRIES = eilt_pkg::EILT_TABLE_ENTRIES,
	parameter int VERTEX_BITS   = eilt_pkg::EILT_VERTEX_BITS,
	parameter int POSITION_BITS = eilt_pkg::EILT_POSITION_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire eilt_pkg::eilt_cmd_t      cmd,
	output eilt_pkg::eilt_stat_t          stat,
	input  wire logic                     in_opcode,
	input  wire logic [VERTEX_BITS-1:0]   in_va,
	input  wire logic [VERTEX_BITS-1:0]   in_vb,
	input  wire logic [POSITION_BITS-1:0] in_pos,
	input  wire logic                     in_start,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    out_status,
	output logic [POSITION_BITS:0]        out_pos
);
	import eilt_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int KW = 2 * VERTEX_BITS;
	localparam int DW = 1 + KW + POSITION_BITS;
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW:0] ENTRIES = (AW+1)'(TABLE_ENTRIES);

	logic                     walk;
	logic [VERTEX_BITS-1:0]   ka, kb;
	logic [KW-1:0]            key;
	logic [AW-1:0]            fold, hash;

	logic                     op_ins_q;
	logic [KW-1:0]            key_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [AW-1:0]            addr_q, probe_q, clr_q;
	logic [VERTEX_BITS-1:0]   prev_q;
	logic                     have_prev_q;
	logic [1:0]               res_status_q;
	logic [POSITION_BITS:0]   res_pos_q;
	logic                     out_valid_q;
	logic [1:0]               out_status_q;
	logic [POSITION_BITS:0]   out_pos_q;

	logic                     we;
	logic [AW-1:0]            waddr;
	logic [DW-1:0]            wdata, rdata;
	logic                     r_valid;
	logic [KW-1:0]            r_key;
	logic [POSITION_BITS-1:0] r_val;

	always_comb begin
		walk = (in_opcode == OP_WALK);
		ka   = walk ? prev_q : in_va;
		kb   = walk ? in_va : in_vb;
		key  = (ka > kb) ? {kb, ka} : {ka, kb};
		fold = '0;
		for (int i = 0; i < KW; i++) begin
			fold[i % AW] = fold[i % AW] ^ key[i];
		end
		hash = ({1'b0, fold} >= ENTRIES) ? fold - ENTRIES[AW-1:0] : fold;
	end

	assign r_valid = rdata[DW-1];
	assign r_key   = rdata[DW-2 -: KW];
	assign r_val   = rdata[POSITION_BITS-1:0];

	assign stat.needs_probe = !walk || (!in_start && have_prev_q);
	assign stat.clr_last    = (clr_q == LAST);
	assign stat.hit         = r_valid && (r_key == key_q);
	assign stat.empty       = !r_valid;
	assign stat.last_probe  = (probe_q == LAST);
	assign stat.is_insert   = op_ins_q;
	assign stat.out_free    = !out_valid_q || out_ready;

	assign we    = cmd.clr_step || cmd.wr;
	assign waddr = cmd.clr_step ? clr_q : addr_q;
	assign wdata = cmd.clr_step ? '0 : {1'b1, key_q, pos_q};

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_pos    = out_pos_q;

	eilt_ram #(
		.WIDTH(DW),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept && walk) begin
				prev_q      <= in_va;
				have_prev_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_ins_q <= !walk;
			key_q    <= key;
			pos_q    <= in_pos;
			addr_q   <= hash;
			probe_q  <= '0;
		end else if (cmd.advance) begin
			addr_q  <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (cmd.cmp) begin
			priority if (stat.hit) begin
				res_status_q <= ST_FOUND;
				res_pos_q    <= {1'b0, r_val} + 1'b1;
			end else if (op_ins_q) begin
				res_status_q <= ST_FULL;
				res_pos_q    <= '0;
			end else begin
				res_status_q <= ST_MISS;
				res_pos_q    <= '0;
			end
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
		end
	end

endmodule
`default_nettype wire

/* sv/edge_index_lookup_table.sv */
// Edge lookup over an open-addressed hash table of TABLE_ENTRIES slots, one RAM read per
// probe. After reset a clearing pass clears every slot before the first beat is taken. An
// insert or a walk lookup reads and compares one slot per probe, moving on after a collision;
// a walk start only records its vertex. Probes run through the single registered RAM read
// port. A full table costs TABLE_ENTRIES probes for a new key. A pending result waits in the
// output register while the next beat is taken.
`default_nettype none
`include "assert_macros.svh"
module edge_index_lookup_table #(
	parameter int TABLE_ENTRIES = eilt_pkg::EILT_TABLE_ENTRIES,
	parameter int VERTEX_BITS   = eilt_pkg::EILT_VERTEX_BITS,
	parameter int POSITION_BITS = eilt_pkg::EILT_POSITION_BITS,
	localparam int IN_W  = ((2 * VERTEX_BITS + POSITION_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((POSITION_BITS + 3 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// vertex_a, vertex_b, simplex_position
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// opcode, walk_start
	input  wire logic [1:0]       s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// status, edge_position
	output logic      [OUT_W-1:0] m_axis_tdata
);
	import eilt_pkg::*;

	eilt_cmd_t                cmd;
	eilt_stat_t               stat;
	logic [1:0]               out_status;
	logic [POSITION_BITS:0]   out_pos;

	eilt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	eilt_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.VERTEX_BITS  (VERTEX_BITS),
		.POSITION_BITS(POSITION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_opcode (s_axis_tuser[0]),
		.in_va     (s_axis_tdata[VERTEX_BITS-1:0]),
		.in_vb     (s_axis_tdata[2*VERTEX_BITS-1:VERTEX_BITS]),
		.in_pos    (s_axis_tdata[2*VERTEX_BITS+POSITION_BITS-1:2*VERTEX_BITS]),
		.in_start  (s_axis_tuser[1]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(out_status),
		.out_pos   (out_pos)
	);

	assign m_axis_tdata = OUT_W'({out_pos, out_status});

	`ASSERT_IMPLIES(a_clear_blocks_input, cmd.clr_step, !s_axis_tready, "beat taken during clear")
	`ASSERT_IMPLIES(a_write_empty_slot, cmd.wr, stat.empty && stat.is_insert, "bad slot write")
	`ASSERT_IMPLIES(a_result_from_emit, $rose(m_axis_tvalid), $past(cmd.emit), "stray result")
	`ASSERT_NEVER(a_status_code, m_axis_tvalid && (out_status == ST_UNUSED), "bad status code")

endmodule
`default_nettype wire
